/* design/recording_record_deframer_defines.svh */
// Assertion macros shared by the deframer's checker
`ifndef RECORDING_RECORD_DEFRAMER_DEFINES_SVH
`define RECORDING_RECORD_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define RRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/rrd_pkg.sv */
// Types, codes and constants of the recording record deframer
package rrd_pkg;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       final_byte;
	} rrd_in_t;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  data_byte;
		logic [2:0]  status;
		logic [31:0] delay_frame_count;
		logic [31:0] total_frame_count;
		logic        run_end;
	} rrd_out_t;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_TYPE,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_STR_ONE,
		PH_SKIP,
		PH_STR_A,
		PH_STR_B,
		PH_HALT
	} phase_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_FILL,
		SQ_REPORT
	} seq_t;

	typedef enum logic [1:0] {
		OUT_DATA,
		OUT_ZERO,
		OUT_REPORT
	} out_sel_t;

	localparam logic [2:0] STAT_OK             = 3'd0;
	localparam logic [2:0] STAT_TOO_SHORT      = 3'd1;
	localparam logic [2:0] STAT_BAD_MAGIC      = 3'd2;
	localparam logic [2:0] STAT_HDR_INCOMPLETE = 3'd3;
	localparam logic [2:0] STAT_NO_FRAMES      = 3'd4;
	localparam logic [2:0] STAT_LEN_MISMATCH   = 3'd5;

	localparam logic [7:0] REC_INPUT  = 8'h12;
	localparam logic [7:0] REC_CHAT   = 8'h14;
	localparam logic [7:0] REC_DROP   = 8'h08;
	localparam logic [7:0] MAGIC_VER0 = 8'h30;
	localparam logic [7:0] MAGIC_VER1 = 8'h31;

	localparam logic [31:0] MAGIC_LEN      = 32'd3;
	localparam logic [31:0] HDR_SHORT_LEN  = 32'd272;
	localparam logic [31:0] HDR_LONG_LEN   = 32'd400;
	localparam logic [31:0] PLAYER_OFS     = 32'd268;
	localparam logic [31:0] PLAYER_END     = 32'd272;
	localparam logic [15:0] SKIP_TAIL      = 16'd4;

	// Status from the datapath to the controller
	typedef struct packed {
		logic past_end;
		logic last_byte;
		logic magic_fail;
		logic header_done;
		logic byte_zero;
		logic type_input;
		logic type_chat;
		logic type_drop;
		logic rec_len_zero;
		logic rec_overrun;
		logic part_last;
		logic fill_last;
		logic in_final;
		logic final_q;
	} dp_stat_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic     take_byte;
		logic     hdr_update;
		logic     len_lo_load;
		logic     frame_open;
		logic     frame_empty;
		logic     part_load_four;
		logic     part_dec;
		logic     fill_dec;
		logic     out_load;
		out_sel_t out_sel;
		logic     out_run_end;
		logic     clear_parse;
	} dp_cmd_t;

	function automatic logic [7:0] magic_prefix(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0: v = 8'h4B;
			2'd1: v = 8'h52;
			default: v = 8'h43;
		endcase
		return v;
	endfunction

endpackage

/* design/recording_record_deframer.sv */
// Recording record deframer: header check, record walk and end-of-file report.
// Takes one file byte a cycle while the output word is free or being taken; an
// empty input record emits players*4 zero words, one a cycle while the word is
// free or being taken, and input stalls until the last of them is loaded; the
// final byte is followed by the status report; the single output register and
// the sequencer stall input until it is loaded. Write file_length while idle.
module recording_record_deframer
	import rrd_pkg::*;
#(
	parameter int MAX_PLAYERS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  rrd_in_t     byte_data,
	output logic        item_valid,
	input  logic        item_ready,
	output rrd_out_t    item_data
);

	dp_stat_t stat;
	dp_cmd_t  cmd;

	rrd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	rrd_datapath #(
		.MAX_PLAYERS (MAX_PLAYERS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_in   (byte_data),
		.cmd       (cmd),
		.stat      (stat),
		.item_out  (item_data)
	);

endmodule

/* design/rrd_datapath.sv */
// Datapath of the deframer: position, header checks, record counters and output register
module rrd_datapath
	import rrd_pkg::*;
#(
	parameter int MAX_PLAYERS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  rrd_in_t     byte_in,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output rrd_out_t    item_out
);

	localparam int PCW = $clog2(MAX_PLAYERS + 1);
	localparam int FW  = $clog2(4 * MAX_PLAYERS + 1);

	logic [31:0] len_q;
	logic [31:0] pos_q;
	logic [2:0]  magic_q;
	logic        long_q;
	logic [31:0] player_q;
	logic [15:0] part_q;
	logic [7:0]  len_lo_q;
	logic        delay_period_q;
	logic [31:0] delay_q;
	logic [31:0] total_q;
	logic [FW-1:0] fill_q;
	logic        final_q;
	logic        mismatch_q;
	rrd_out_t    out_q;

	logic [7:0]  b;
	logic [32:0] pos_inc;
	logic [15:0] rec_len;
	logic [33:0] rec_end;
	logic [2:0]  magic_nx;
	logic [PCW-1:0] players;
	logic [FW-1:0]  fill_cnt;
	logic [2:0]  report_status;
	logic        in_player_word;
	rrd_out_t    out_nx;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	assign b        = byte_in.byte_value;
	assign pos_inc  = {1'b0, pos_q} + 33'd1;
	assign rec_len  = {b, len_lo_q};
	assign rec_end  = {1'b0, pos_inc} + {18'd0, rec_len};
	assign in_player_word = (pos_q >= PLAYER_OFS) && (pos_q < PLAYER_END);

	always_comb begin
		magic_nx = magic_q;
		if (pos_q < MAGIC_LEN) begin
			if (b != magic_prefix(pos_q[1:0]))
				magic_nx[0] = 1'b0;
		end else if (pos_q == MAGIC_LEN) begin
			if (b != MAGIC_VER0)
				magic_nx[1] = 1'b0;
			if (b != MAGIC_VER1)
				magic_nx[2] = 1'b0;
		end
	end

	// Clamp the signed player word to 1..MAX_PLAYERS
	always_comb begin
		if (player_q[31] || player_q == 32'd0)
			players = PCW'(1);
		else if (player_q > 32'(MAX_PLAYERS))
			players = PCW'(MAX_PLAYERS);
		else
			players = player_q[PCW-1:0];
		fill_cnt = FW'({players, 2'b00});
	end

	always_comb begin
		stat.past_end     = pos_q >= len_q;
		stat.last_byte    = pos_inc >= {1'b0, len_q};
		stat.magic_fail   = (pos_q == MAGIC_LEN) && (!magic_nx[0] || magic_nx[2:1] == 2'b00);
		stat.header_done  = pos_q == (long_q ? HDR_LONG_LEN - 32'd1 : HDR_SHORT_LEN - 32'd1);
		stat.byte_zero    = b == 8'd0;
		stat.type_input   = b == REC_INPUT;
		stat.type_chat    = b == REC_CHAT;
		stat.type_drop    = b == REC_DROP;
		stat.rec_len_zero = rec_len == 16'd0;
		stat.rec_overrun  = rec_end > {2'b00, len_q};
		stat.part_last    = part_q <= 16'd1;
		stat.fill_last    = fill_q == FW'(1);
		stat.in_final     = byte_in.final_byte;
		stat.final_q      = final_q;
	end

	always_comb begin
		if (len_q < HDR_SHORT_LEN)
			report_status = STAT_TOO_SHORT;
		else if (mismatch_q)
			report_status = STAT_LEN_MISMATCH;
		else if (!magic_q[0] || magic_q[2:1] == 2'b00)
			report_status = STAT_BAD_MAGIC;
		else if (long_q && len_q < HDR_LONG_LEN)
			report_status = STAT_HDR_INCOMPLETE;
		else if (total_q == 32'd0)
			report_status = STAT_NO_FRAMES;
		else
			report_status = STAT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			magic_q        <= 3'b111;
			long_q         <= 1'b0;
			player_q       <= '0;
			part_q         <= '0;
			len_lo_q       <= '0;
			delay_period_q <= 1'b1;
			delay_q        <= '0;
			total_q        <= '0;
			fill_q         <= '0;
			final_q        <= 1'b0;
			mismatch_q     <= 1'b0;
		end else if (cmd.clear_parse) begin
			pos_q          <= '0;
			magic_q        <= 3'b111;
			long_q         <= 1'b0;
			player_q       <= '0;
			part_q         <= '0;
			len_lo_q       <= '0;
			delay_period_q <= 1'b1;
			delay_q        <= '0;
			total_q        <= '0;
			fill_q         <= '0;
			final_q        <= 1'b0;
			mismatch_q     <= 1'b0;
		end else begin
			if (cmd.take_byte) begin
				pos_q      <= sat_inc(pos_q);
				final_q    <= byte_in.final_byte;
				mismatch_q <= pos_inc != {1'b0, len_q};
			end
			if (cmd.hdr_update) begin
				magic_q <= magic_nx;
				if (pos_q == MAGIC_LEN && !stat.magic_fail)
					long_q <= magic_nx[2];
				if (in_player_word)
					player_q[{pos_q[1:0], 3'b000} +: 8] <= b;
			end
			if (cmd.len_lo_load)
				len_lo_q <= b;
			if (cmd.frame_open) begin
				delay_period_q <= 1'b0;
				total_q        <= sat_inc(total_q);
				part_q         <= rec_len;
			end
			if (cmd.frame_empty) begin
				if (delay_period_q)
					delay_q <= sat_inc(delay_q);
				total_q <= sat_inc(total_q);
				// first zero goes out with the record byte itself
				fill_q  <= fill_cnt - FW'(1);
			end
			if (cmd.part_load_four)
				part_q <= SKIP_TAIL;
			if (cmd.part_dec)
				part_q <= stat.part_last ? 16'd0 : part_q - 16'd1;
			if (cmd.fill_dec)
				fill_q <= fill_q - FW'(1);
		end
	end

	always_comb begin
		out_nx         = '0;
		out_nx.run_end = cmd.out_run_end;
		case (cmd.out_sel)
			OUT_DATA: begin
				out_nx.data_byte = b;
			end
			OUT_REPORT: begin
				out_nx.item_kind         = 1'b1;
				out_nx.status            = report_status;
				out_nx.delay_frame_count = delay_q;
				out_nx.total_frame_count = total_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (cmd.out_load) begin
			out_q <= out_nx;
		end
	end

	assign item_out = out_q;

endmodule

/* design/rrd_ctrl.sv */
// Controller of the deframer: record parse phase and output sequencing
module rrd_ctrl
	import rrd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	output logic     item_valid,
	input  logic     item_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	seq_t   seq_q, seq_d;
	phase_t phase_q, phase_d, phase_nx;
	logic   out_valid_q, out_valid_d;

	logic slot_free;
	logic accept;
	logic load;
	logic act_hdr, act_len_lo, act_open, act_empty, act_four, act_dec;
	logic emit_data, emit_fill;

	assign slot_free  = !out_valid_q || item_ready;
	assign byte_ready = (seq_q == SQ_IDLE) && slot_free;
	assign accept     = byte_ready && byte_valid;
	assign item_valid = out_valid_q;
	assign load       = (accept && (emit_data || emit_fill))
		|| ((seq_q == SQ_FILL || seq_q == SQ_REPORT) && slot_free);

	// Decode what the word at the input does in the current phase
	always_comb begin
		phase_nx   = phase_q;
		act_hdr    = 1'b0;
		act_len_lo = 1'b0;
		act_open   = 1'b0;
		act_empty  = 1'b0;
		act_four   = 1'b0;
		act_dec    = 1'b0;
		emit_data  = 1'b0;
		emit_fill  = 1'b0;
		if (stat.past_end) begin
			phase_nx = PH_HALT;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					act_hdr = 1'b1;
					if (stat.magic_fail)
						phase_nx = PH_HALT;
					else if (stat.header_done)
						phase_nx = PH_TYPE;
				end
				PH_TYPE: begin
					if (stat.last_byte)
						phase_nx = PH_HALT;
					else if (stat.type_input)
						phase_nx = PH_LEN_LO;
					else if (stat.type_chat)
						phase_nx = PH_STR_ONE;
					else if (stat.type_drop)
						phase_nx = PH_STR_A;
					else
						phase_nx = PH_HALT;
				end
				PH_LEN_LO: begin
					if (stat.last_byte) begin
						phase_nx = PH_HALT;
					end else begin
						act_len_lo = 1'b1;
						phase_nx   = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					if (stat.rec_len_zero) begin
						act_empty = 1'b1;
						emit_fill = 1'b1;
						phase_nx  = PH_TYPE;
					end else if (stat.rec_overrun) begin
						phase_nx = PH_HALT;
					end else begin
						act_open = 1'b1;
						phase_nx = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					emit_data = 1'b1;
					act_dec   = 1'b1;
					if (stat.part_last)
						phase_nx = PH_TYPE;
				end
				PH_STR_ONE: begin
					if (stat.byte_zero) begin
						act_four = 1'b1;
						phase_nx = PH_SKIP;
					end
				end
				PH_SKIP: begin
					act_dec = 1'b1;
					if (stat.part_last)
						phase_nx = PH_TYPE;
				end
				PH_STR_A: begin
					if (stat.byte_zero)
						phase_nx = PH_STR_B;
				end
				PH_STR_B: begin
					if (stat.byte_zero)
						phase_nx = PH_TYPE;
				end
				default: begin
					phase_nx = PH_HALT;
				end
			endcase
		end
	end

	// Next state
	always_comb begin
		seq_d   = seq_q;
		phase_d = phase_q;
		case (seq_q)
			SQ_IDLE: begin
				if (accept) begin
					phase_d = phase_nx;
					if (emit_fill)
						seq_d = SQ_FILL;
					else if (stat.in_final)
						seq_d = SQ_REPORT;
				end
			end
			SQ_FILL: begin
				if (slot_free && stat.fill_last)
					seq_d = stat.final_q ? SQ_REPORT : SQ_IDLE;
			end
			SQ_REPORT: begin
				if (slot_free) begin
					seq_d   = SQ_IDLE;
					phase_d = PH_HEADER;
				end
			end
			default: begin
				seq_d = SQ_IDLE;
			end
		endcase
		if (load)
			out_valid_d = 1'b1;
		else if (item_ready)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	// Commands
	always_comb begin
		cmd                = '0;
		cmd.out_sel        = OUT_DATA;
		cmd.take_byte      = accept;
		cmd.hdr_update     = accept && act_hdr;
		cmd.len_lo_load    = accept && act_len_lo;
		cmd.frame_open     = accept && act_open;
		cmd.frame_empty    = accept && act_empty;
		cmd.part_load_four = accept && act_four;
		cmd.part_dec       = accept && act_dec;
		case (seq_q)
			SQ_IDLE: begin
				if (accept && emit_data) begin
					cmd.out_load    = 1'b1;
					cmd.out_sel     = OUT_DATA;
					cmd.out_run_end = !stat.in_final;
				end else if (accept && emit_fill) begin
					cmd.out_load    = 1'b1;
					cmd.out_sel     = OUT_ZERO;
					cmd.out_run_end = 1'b0;
				end
			end
			SQ_FILL: begin
				if (slot_free) begin
					cmd.out_load    = 1'b1;
					cmd.out_sel     = OUT_ZERO;
					cmd.out_run_end = stat.fill_last && !stat.final_q;
					cmd.fill_dec    = 1'b1;
				end
			end
			SQ_REPORT: begin
				if (slot_free) begin
					cmd.out_load    = 1'b1;
					cmd.out_sel     = OUT_REPORT;
					cmd.out_run_end = 1'b1;
					cmd.clear_parse = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SQ_IDLE;
			phase_q     <= PH_HEADER;
			out_valid_q <= 1'b0;
		end else begin
			seq_q       <= seq_d;
			phase_q     <= phase_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

/* design/rrd_checker.sv */
// Port checker for the deframer, bound to the top level
`include "recording_record_deframer_defines.svh"

module rrd_checker
	import rrd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     byte_valid,
	input logic     byte_ready,
	input rrd_in_t  byte_data,
	input logic     item_valid,
	input logic     item_ready,
	input rrd_out_t item_data
);

	`RRD_ASSERT_NEXT(a_item_hold, clk, arst_n, item_valid && !item_ready, item_valid && $stable(item_data), "stalled output word changed")

	`RRD_ASSERT_NOW(a_ready_needs_slot, clk, arst_n, byte_ready && item_valid, item_ready, "input taken while output word blocked")

	`RRD_ASSERT_NOW(a_report_ends_run, clk, arst_n, item_valid && item_data.item_kind, item_data.run_end, "status report not last of its run")

	`RRD_ASSERT_NOW(a_data_clean, clk, arst_n, item_valid && !item_data.item_kind, item_data.status == STAT_OK && item_data.delay_frame_count == 32'd0 && item_data.total_frame_count == 32'd0, "data word carries report fields")

	`RRD_ASSERT_NEXT(a_final_stalls, clk, arst_n, byte_valid && byte_ready && byte_data.final_byte, !byte_ready, "input taken before report of final byte")

endmodule

bind recording_record_deframer rrd_checker u_rrd_checker (.*);

/* sim/deframer_checker.sv */
// Checker for the record deframer: predicts the output words from the byte stream and compares them
`timescale 1ns / 100ps
module deframer_checker
	import rrd_pkg::*;
#(
	parameter int MAX_PLAYERS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        byte_valid,
	input  logic        byte_ready,
	input  rrd_in_t     byte_data,
	input  logic        item_valid,
	input  logic        item_ready,
	input  rrd_out_t    item_data,
	output int          fail_count,
	output int          pending
);

	logic [31:0] file_len;
	logic [31:0] position;
	phase_t      phase;
	logic        prefix_ok;
	logic        ver0_ok;
	logic        ver1_ok;
	logic        long_hdr;
	logic [31:0] player_word;
	logic [15:0] part_left;
	logic [7:0]  len_lo;
	logic        in_delay;
	logic [31:0] delay_frames;
	logic [31:0] total_frames;
	rrd_out_t    expected_words[$];

	initial fail_count = 0;

	function automatic logic [7:0] head_char(input logic [1:0] idx);
		case (idx)
			2'd0: return 8'h4B;
			2'd1: return 8'h52;
			default: return 8'h43;
		endcase
	endfunction

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// Negative or zero counts read as one player
	function automatic logic [31:0] seat_count();
		if (player_word[31] || player_word == '0)
			return 32'd1;
		if (player_word > 32'(MAX_PLAYERS))
			return 32'(MAX_PLAYERS);
		return player_word;
	endfunction

	task automatic reset_walk();
		position = '0;
		phase = PH_HEADER;
		prefix_ok = 1'b1;
		ver0_ok = 1'b1;
		ver1_ok = 1'b1;
		long_hdr = 1'b0;
		player_word = '0;
		part_left = '0;
		len_lo = '0;
		in_delay = 1'b1;
		delay_frames = '0;
		total_frames = '0;
	endtask

	task automatic push_word(input logic kind, input logic [7:0] data, input logic [2:0] st);
		rrd_out_t w;
		w = '0;
		w.item_kind = kind;
		w.data_byte = data;
		w.status = st;
		if (kind) begin
			w.delay_frame_count = delay_frames;
			w.total_frame_count = total_frames;
		end
		expected_words.push_back(w);
	endtask

	task automatic predict_deframe(input logic [7:0] b, input logic last);
		longint unsigned pos;
		longint unsigned len;
		logic [15:0]     rec_len;
		logic [2:0]      st;
		int              queued;
		rrd_out_t        w;
		pos = position;
		len = file_len;
		queued = expected_words.size();
		position = bump(position);
		// anything at or past the preset length is dropped
		if (pos >= len)
			phase = PH_HALT;
		case (phase)
			PH_HEADER: begin
				if (pos < MAGIC_LEN) begin
					if (b != head_char(pos[1:0]))
						prefix_ok = 1'b0;
				end else if (pos == MAGIC_LEN) begin
					if (b != MAGIC_VER0)
						ver0_ok = 1'b0;
					if (b != MAGIC_VER1)
						ver1_ok = 1'b0;
					if (!prefix_ok || !(ver0_ok || ver1_ok))
						phase = PH_HALT;
					else
						long_hdr = ver1_ok;
				end else if (pos >= PLAYER_OFS && pos < PLAYER_END) begin
					player_word |= 32'(b) << (8 * (pos - PLAYER_OFS));
				end
				if (phase == PH_HEADER &&
				    pos == (long_hdr ? HDR_LONG_LEN : HDR_SHORT_LEN) - 1)
					phase = PH_TYPE;
			end
			PH_TYPE: begin
				if (pos + 1 >= len)
					phase = PH_HALT;
				else if (b == REC_INPUT)
					phase = PH_LEN_LO;
				else if (b == REC_CHAT)
					phase = PH_STR_ONE;
				else if (b == REC_DROP)
					phase = PH_STR_A;
				else
					phase = PH_HALT;
			end
			PH_LEN_LO: begin
				if (pos + 1 >= len) begin
					phase = PH_HALT;
				end else begin
					len_lo = b;
					phase = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				rec_len = {b, len_lo};
				if (rec_len != '0) begin
					if (pos + 1 + rec_len > len) begin
						phase = PH_HALT;
					end else begin
						in_delay = 1'b0;
						total_frames = bump(total_frames);
						part_left = rec_len;
						phase = PH_PAYLOAD;
					end
				end else begin
					if (in_delay)
						delay_frames = bump(delay_frames);
					total_frames = bump(total_frames);
					repeat (seat_count() * 4)
						push_word(1'b0, 8'h00, STAT_OK);
					phase = PH_TYPE;
				end
			end
			PH_PAYLOAD: begin
				push_word(1'b0, b, STAT_OK);
				if (part_left <= 16'd1) begin
					part_left = '0;
					phase = PH_TYPE;
				end else begin
					part_left--;
				end
			end
			PH_STR_ONE: begin
				if (b == 8'h00) begin
					part_left = SKIP_TAIL;
					phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (part_left <= 16'd1) begin
					part_left = '0;
					phase = PH_TYPE;
				end else begin
					part_left--;
				end
			end
			PH_STR_A: begin
				if (b == 8'h00)
					phase = PH_STR_B;
			end
			PH_STR_B: begin
				if (b == 8'h00)
					phase = PH_TYPE;
			end
			default: phase = PH_HALT;
		endcase

		if (last) begin
			if (file_len < HDR_SHORT_LEN)
				st = STAT_TOO_SHORT;
			else if (pos + 1 != len)
				st = STAT_LEN_MISMATCH;
			else if (!prefix_ok || !(ver0_ok || ver1_ok))
				st = STAT_BAD_MAGIC;
			else if (long_hdr && file_len < HDR_LONG_LEN)
				st = STAT_HDR_INCOMPLETE;
			else if (total_frames == '0)
				st = STAT_NO_FRAMES;
			else
				st = STAT_OK;
			push_word(1'b1, 8'h00, st);
			reset_walk();
		end

		// mark the last word this byte produced
		if (expected_words.size() > queued) begin
			w = expected_words.pop_back();
			w.run_end = 1'b1;
			expected_words.push_back(w);
		end
	endtask

	task automatic note_mismatch(input string field, input logic [31:0] want,
	                             input logic [31:0] got);
		fail_count++;
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
	endtask

	task automatic compare_word(input rrd_out_t got);
		rrd_out_t want;
		if (expected_words.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected output word, expected none, got %h", $time, got);
			return;
		end
		want = expected_words.pop_front();
		if (got.item_kind !== want.item_kind)
			note_mismatch("item_kind", want.item_kind, got.item_kind);
		if (got.data_byte !== want.data_byte)
			note_mismatch("data_byte", want.data_byte, got.data_byte);
		if (got.status !== want.status)
			note_mismatch("status", want.status, got.status);
		if (got.delay_frame_count !== want.delay_frame_count)
			note_mismatch("delay_frame_count", want.delay_frame_count,
			              got.delay_frame_count);
		if (got.total_frame_count !== want.total_frame_count)
			note_mismatch("total_frame_count", want.total_frame_count,
			              got.total_frame_count);
		if (got.run_end !== want.run_end)
			note_mismatch("run_end", want.run_end, got.run_end);
	endtask

	// Retire the outgoing word before predicting from the incoming one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_len = '0;
			reset_walk();
			expected_words.delete();
		end else begin
			if (item_valid && item_ready)
				compare_word(item_data);
			if (cfg_we)
				file_len = cfg_wdata;
			if (byte_valid && byte_ready)
				predict_deframe(byte_data.byte_value, byte_data.final_byte);
		end
		pending = expected_words.size();
	end

endmodule

/* sim/tb_top.sv */
// Testbench top for the record deframer: clock, reset, length writes, recording stimulus, verdict
`timescale 1ns / 100ps
module tb_top;
	import rrd_pkg::*;

	localparam int SEATS_MAX     = 4;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 400;

	typedef enum int {
		MAGIC_SHORT,
		MAGIC_LONG,
		MAGIC_BROKEN
	} magic_kind_t;

	typedef enum int {
		TAIL_CLEAN,
		TAIL_UNKNOWN,
		TAIL_OVERRUN,
		TAIL_OPEN_STRING,
		TAIL_CUT
	} tail_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	rrd_in_t     byte_data = '0;
	logic        item_valid;
	logic        item_ready = 1'b0;
	rrd_out_t    item_data;
	int          fail_count;
	int          pending;
	int          hold_requests = 0;
	logic [7:0]  file_bytes[$];

	recording_record_deframer #(
		.MAX_PLAYERS(SEATS_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data (byte_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item_data (item_data)
	);

	deframer_checker #(
		.MAX_PLAYERS(SEATS_MAX)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data (byte_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item_data (item_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// Output side: a random, possibly empty, gap before every word, and a long hold-off on request
	initial begin : receive_words
		int gap;
		int served;
		served = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_requests != served) begin
				served = hold_requests;
				gap = LONG_HOLD;
			end else begin
				gap = $urandom_range(0, 18);
			end
			if (gap > 0) begin
				item_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			item_ready <= 1'b1;
			do @(posedge clk); while (!(item_valid && item_ready));
		end
	end

	task automatic write_length(input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] value, input logic last);
		int gap;
		gap = $urandom_range(0, 18);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= '{byte_value: value, final_byte: last};
		do @(posedge clk); while (!byte_ready);
	endtask

	// Hold the input until every expected word is out, then let the block settle
	task automatic settle();
		byte_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic play_file(input logic [31:0] len_reg, input int pause_at, input int hold_at);
		write_length(len_reg);
		foreach (file_bytes[i]) begin
			if (i == hold_at)
				hold_requests++;
			if (i == pause_at)
				settle();
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		end
		settle();
	endtask

	function automatic logic [7:0] any_nonzero();
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic start_recording(input magic_kind_t kind, input logic [31:0] seats);
		int hdr_len;
		int spot;
		hdr_len = (kind == MAGIC_LONG) ? HDR_LONG_LEN : HDR_SHORT_LEN;
		file_bytes.delete();
		repeat (hdr_len) file_bytes.push_back(8'($urandom));
		file_bytes[0] = 8'h4B;
		file_bytes[1] = 8'h52;
		file_bytes[2] = 8'h43;
		file_bytes[3] = (kind == MAGIC_LONG) ? MAGIC_VER1 : MAGIC_VER0;
		// mask is never 1, so the version byte cannot land on the other valid one
		if (kind == MAGIC_BROKEN) begin
			spot = $urandom_range(0, 3);
			file_bytes[spot] = file_bytes[spot] ^ 8'($urandom_range(2, 255));
		end
		for (int k = 0; k < 4; k++)
			file_bytes[PLAYER_OFS + k] = seats[8*k +: 8];
	endtask

	task automatic add_string();
		repeat ($urandom_range(0, 5)) file_bytes.push_back(any_nonzero());
		file_bytes.push_back(8'h00);
	endtask

	task automatic add_frame(input int unsigned size);
		file_bytes.push_back(REC_INPUT);
		file_bytes.push_back(size[7:0]);
		file_bytes.push_back(size[15:8]);
		repeat (size) file_bytes.push_back(8'($urandom));
	endtask

	task automatic add_chat();
		file_bytes.push_back(REC_CHAT);
		add_string();
		repeat (SKIP_TAIL) file_bytes.push_back(8'($urandom));
	endtask

	task automatic add_drop();
		file_bytes.push_back(REC_DROP);
		add_string();
		add_string();
	endtask

	task automatic close_recording(input tail_kind_t tail);
		logic [7:0] code;
		case (tail)
			TAIL_UNKNOWN: begin
				do code = 8'($urandom);
				while (code == REC_INPUT || code == REC_CHAT || code == REC_DROP);
				file_bytes.push_back(code);
				repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
			end
			TAIL_OVERRUN: begin
				// both length bytes nonzero, so the record runs well past the end
				file_bytes.push_back(REC_INPUT);
				file_bytes.push_back(any_nonzero());
				file_bytes.push_back(any_nonzero());
				repeat (3) file_bytes.push_back(8'($urandom));
			end
			TAIL_OPEN_STRING: begin
				file_bytes.push_back(($urandom_range(0, 1) == 0) ? REC_CHAT : REC_DROP);
				repeat ($urandom_range(1, 8)) file_bytes.push_back(any_nonzero());
			end
			TAIL_CUT: begin
				repeat ($urandom_range(1, 3)) void'(file_bytes.pop_back());
			end
			default: ;
		endcase
	endtask

	initial begin : stimulus
		int hold_at;
		int pause_at;
		wait (arst_n);
		@(posedge clk);

		// runt file with a zero length: all bytes lie past the end
		file_bytes = '{8'h4B, 8'h52, 8'h43};
		play_file(32'd0, -1, -1);

		// largest length, file cut short
		file_bytes = '{8'h4B, 8'h52, 8'h43, MAGIC_VER0, 8'hFF, 8'h00};
		play_file(32'hFFFF_FFFF, -1, -1);

		// unknown version byte: parsing stops at the fourth byte
		file_bytes = '{8'h4B, 8'h52, 8'h43, 8'h32, REC_INPUT, 8'h00};
		play_file(32'd6, -1, -1);

		// clamped player count, every record type, empty frames before and after data,
		// overrunning last record
		start_recording(MAGIC_SHORT, 32'd7);
		// hold the output while a run of empty frames floods in
		hold_at = file_bytes.size();
		repeat (3) add_frame(0);
		add_frame(3);
		add_frame(0);
		add_chat();
		add_drop();
		add_frame(0);
		pause_at = file_bytes.size();
		add_frame(5);
		close_recording(TAIL_OVERRUN);
		play_file(file_bytes.size(), pause_at, hold_at);

		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
